### rtl/uq4_pkg.sv
// ----------------------------------------------------------------------------
// uq4_pkg
// Types, constants and float helpers for the 4-bit block quantizer.
// ----------------------------------------------------------------------------
package uq4_pkg;

  typedef struct packed {
    logic [31:0] sample_bits;
    logic        final_sample;
  } in_word_t;

  typedef struct packed {
    logic [15:0] scale_half;
    logic [15:0] zero_half;
    logic [5:0]  byte_index;
    logic [7:0]  packed_byte;
    logic        last_byte;
  } out_word_t;

  localparam logic [31:0] F_MAX_POS   = 32'h7F7F_FFFF;
  localparam logic [31:0] F_MAX_NEG   = 32'hFF7F_FFFF;
  localparam logic [31:0] F_MIN_RANGE = 32'h322B_CC77; // 1e-8
  localparam logic [31:0] F_POS_INF   = 32'h7F80_0000;
  localparam logic [31:0] F_QNAN      = 32'h7FC0_0000;
  localparam logic [15:0] H_INF       = 16'h7C00;
  localparam logic [15:0] H_MANT      = 16'h03FF;
  localparam logic [15:0] H_SIGN      = 16'h8000;
  localparam logic [3:0]  CODE_MAX    = 4'd15;

  function automatic logic f_is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
  endfunction

  // a < b, IEEE semantics: NaN compares false, signed zeros are equal
  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic res;
    res = 1'b0;
    if (f_is_nan(a) || f_is_nan(b)) begin
      res = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = a[31];
    end else if (!a[31]) begin
      res = a[30:0] < b[30:0];
    end else begin
      res = a[30:0] > b[30:0];
    end
    return res;
  endfunction

  // truncating single to half
  function automatic logic [15:0] f_to_half(input logic [31:0] f);
    logic [15:0] sgn;
    logic [15:0] res;
    sgn = f[31] ? H_SIGN : 16'h0000;
    if (f[30:23] <= 8'd112) begin
      res = sgn;
    end else if (f[30:23] >= 8'd143) begin
      res = sgn | H_INF;
    end else begin
      res = sgn | {1'b0, 5'(f[30:23] - 8'd112), 10'd0} | (16'(f[22:13]) & H_MANT);
    end
    return res;
  endfunction

  // fraction threshold (units of 2^-26) at which q rounds up to integer k
  function automatic logic [25:0] up_thr(input logic [4:0] k);
    logic [5:0] h;
    unique case (k)
      5'd1:                      h = 6'd2;
      5'd2:                      h = 6'd4;
      5'd3, 5'd4:                h = 6'd8;
      5'd5, 5'd6, 5'd7, 5'd8:    h = 6'd16;
      default:                   h = 6'd32;
    endcase
    return 26'(27'h400_0000 - 27'(h));
  endfunction

endpackage

### rtl/uniform_4bit_block_quantizer_core.sv
// ----------------------------------------------------------------------------
// uniform_4bit_block_quantizer_core
// Min/max uniform 4-bit block quantizer with half precision header.
// ----------------------------------------------------------------------------
// A value word is taken while start is high and busy is low; non-final words
// leave busy low. After the final word the block stays busy: it forms the
// range and scale (S_RNG_A to S_RNG_C), then for each stored value does the
// memory read, two subtractor stages, 31 steps of the bit-serial divider and
// the code, pads values past the loaded count with zero codes, and emits each
// packed byte in S_EMIT. Each output word is shown for one cycle under
// out_valid and cannot be held off.
module uniform_4bit_block_quantizer_core #(
  parameter int BLOCK_ELEMENTS = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  uq4_pkg::in_word_t   in_word,
  output logic                busy,
  output logic                out_valid,
  output uq4_pkg::out_word_t  out_word
);
  import uq4_pkg::*;

  localparam int NUM_BYTES = (BLOCK_ELEMENTS + 1) / 2;
  localparam int BW  = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
  localparam int EW  = BW + 1;
  localparam int AW  = $clog2(BLOCK_ELEMENTS);
  localparam int CW  = $clog2(BLOCK_ELEMENTS + 1);
  localparam int MW  = (EW > CW) ? EW : CW;

  typedef enum logic [3:0] {
    S_IDLE, S_RNG_A, S_RNG_B, S_RNG_C, S_ELEM, S_FETCH,
    S_SUB_A, S_SUB_B, S_DIV_GO, S_DIV_WAIT, S_EMIT
  } state_t;

  state_t      state_r;
  logic [CW-1:0] count_r;
  logic [31:0] min_r, max_r, range_r, d_r, rdata_r;
  logic [EW-1:0] elem_r;
  logic [7:0]  pack_r;
  logic [15:0] sh_r, zh_r;
  logic        out_valid_r;
  out_word_t   out_word_r;

  logic [31:0] mem [BLOCK_ELEMENTS];

  logic        accept, store;
  logic [31:0] sub_a, sub_res, scale;
  logic        div_done;
  logic [3:0]  div_code;
  logic        last_b;

  assign accept = start && (state_r == S_IDLE);
  assign store  = accept && (count_r < CW'(BLOCK_ELEMENTS));
  assign sub_a  = (state_r == S_RNG_A) ? max_r : rdata_r;
  assign last_b = elem_r[EW-1:1] == BW'(NUM_BYTES - 1);
  assign scale  = (range_r[30:23] == 8'hFF) ? F_POS_INF :
                  {range_r[31], range_r[30:23] - 8'd4, range_r[22:0]};

  uq4_fsub u_fsub (
    .clk (clk),
    .a   (sub_a),
    .b   (min_r),
    .res (sub_res)
  );

  uq4_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (state_r == S_DIV_GO),
    .d_bits     (d_r),
    .range_bits (range_r),
    .done       (div_done),
    .code       (div_code)
  );

  always_ff @(posedge clk) begin
    if (store) mem[count_r[AW-1:0]] <= in_word.sample_bits;
    rdata_r <= mem[elem_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      min_r       <= F_MAX_POS;
      max_r       <= F_MAX_NEG;
      elem_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (store) begin
            count_r <= count_r + CW'(1);
            if (f_lt(in_word.sample_bits, min_r)) min_r <= in_word.sample_bits;
            if (f_lt(max_r, in_word.sample_bits)) max_r <= in_word.sample_bits;
          end
          if (accept && in_word.final_sample) state_r <= S_RNG_A;
        end
        S_RNG_A: state_r <= S_RNG_B;
        S_RNG_B: begin
          range_r <= f_lt(sub_res, F_MIN_RANGE) ? F_MIN_RANGE : sub_res;
          state_r <= S_RNG_C;
        end
        S_RNG_C: begin
          sh_r    <= f_to_half(scale);
          zh_r    <= f_to_half(min_r);
          elem_r  <= '0;
          pack_r  <= '0;
          state_r <= S_ELEM;
        end
        S_ELEM: begin
          if (MW'(elem_r) < MW'(count_r)) begin
            state_r <= S_FETCH;
          end else begin
            if (elem_r[0]) begin
              pack_r[7:4] <= '0;
              state_r     <= S_EMIT;
            end else begin
              pack_r[3:0] <= '0;
              elem_r      <= elem_r + EW'(1);
            end
          end
        end
        S_FETCH:  state_r <= S_SUB_A;
        S_SUB_A:  state_r <= S_SUB_B;
        S_SUB_B: begin
          d_r     <= sub_res;
          state_r <= S_DIV_GO;
        end
        S_DIV_GO: state_r <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (elem_r[0]) begin
              pack_r[7:4] <= div_code;
              state_r     <= S_EMIT;
            end else begin
              pack_r[3:0] <= div_code;
              elem_r      <= elem_r + EW'(1);
              state_r     <= S_ELEM;
            end
          end
        end
        S_EMIT: begin
          out_valid_r            <= 1'b1;
          out_word_r.scale_half  <= sh_r;
          out_word_r.zero_half   <= zh_r;
          out_word_r.byte_index  <= 6'(elem_r[EW-1:1]);
          out_word_r.packed_byte <= pack_r;
          out_word_r.last_byte   <= last_b;
          pack_r                 <= '0;
          if (last_b) begin
            count_r <= '0;
            min_r   <= F_MAX_POS;
            max_r   <= F_MAX_NEG;
            state_r <= S_IDLE;
          end else begin
            elem_r  <= elem_r + EW'(1);
            state_r <= S_ELEM;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/uq4_fsub.sv
// ----------------------------------------------------------------------------
// uq4_fsub
// Two-stage single precision subtractor a - b, round to nearest even.
// Stage one aligns and adds, stage two normalizes and rounds.
// ----------------------------------------------------------------------------
module uq4_fsub (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res
);
  import uq4_pkg::*;

  logic        sa, sb, a_nan, b_nan, a_inf, b_inf, swp;
  logic [7:0]  ea, eb, ebig, esml, diff;
  logic [23:0] mbig, msml;
  logic [26:0] wide, al, msk;
  logic [27:0] sum;
  logic        spec;
  logic [31:0] spec_val;

  logic        sign_r, sub_r, spec_r;
  logic [31:0] spec_val_r;
  logic [9:0]  e_r;
  logic [27:0] sum_r;

  always_comb begin
    sa    = a[31];
    sb    = ~b[31];
    ea    = a[30:23];
    eb    = b[30:23];
    a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
    spec     = a_nan || b_nan || a_inf || b_inf;
    spec_val = F_QNAN;
    if (a_nan || b_nan) begin
      spec_val = F_QNAN;
    end else if (a_inf && b_inf) begin
      spec_val = (sa == sb) ? {sa, F_POS_INF[30:0]} : F_QNAN;
    end else if (a_inf) begin
      spec_val = {sa, F_POS_INF[30:0]};
    end else if (b_inf) begin
      spec_val = {sb, F_POS_INF[30:0]};
    end
    swp  = b[30:0] > a[30:0];
    ebig = swp ? eb : ea;
    esml = swp ? ea : eb;
    mbig = swp ? {eb != 8'd0, b[22:0]} : {ea != 8'd0, a[22:0]};
    msml = swp ? {ea != 8'd0, a[22:0]} : {eb != 8'd0, b[22:0]};
    if (ebig == 8'd0) ebig = 8'd1;
    if (esml == 8'd0) esml = 8'd1;
    diff = ebig - esml;
    wide = {msml, 3'b000};
    if (diff >= 8'd27) begin
      al  = {26'd0, |msml};
      msk = '0;
    end else begin
      msk = 27'((27'd1 << diff[4:0]) - 27'd1);
      al  = wide >> diff[4:0];
      al[0] = al[0] | (|(wide & msk));
    end
    if (sa == sb) begin
      sum = {1'b0, mbig, 3'b000} + {1'b0, al};
    end else begin
      sum = {1'b0, mbig, 3'b000} - {1'b0, al};
    end
  end

  always_ff @(posedge clk) begin
    sign_r     <= swp ? sb : sa;
    sub_r      <= sa != sb;
    spec_r     <= spec;
    spec_val_r <= spec_val;
    e_r        <= 10'(ebig);
    sum_r      <= sum;
  end

  logic [4:0]  lz;
  logic [9:0]  e_n, nsh;
  logic [26:0] m27;
  logic        up;
  logic [24:0] m25;
  logic [23:0] mant;

  always_comb begin
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (sum_r[i]) lz = 5'(26 - i);
    end
    if (sum_r[27]) begin
      m27 = {sum_r[27:2], sum_r[1] | sum_r[0]};
      e_n = e_r + 10'd1;
      nsh = '0;
    end else begin
      nsh = (10'(lz) < e_r - 10'd1) ? 10'(lz) : e_r - 10'd1;
      m27 = sum_r[26:0] << nsh[4:0];
      e_n = e_r - nsh;
    end
    up  = m27[2] & (m27[1] | m27[0] | m27[3]);
    m25 = {1'b0, m27[26:3]} + 25'(up);
    if (m25[24]) begin
      mant = m25[24:1];
      e_n  = e_n + 10'd1;
    end else begin
      mant = m25[23:0];
    end
    if (spec_r) begin
      res = spec_val_r;
    end else if (sum_r == 28'd0) begin
      res = {sub_r ? 1'b0 : sign_r, 31'd0};
    end else if (e_n >= 10'd255) begin
      res = {sign_r, F_POS_INF[30:0]};
    end else begin
      res = {sign_r, mant[23] ? e_n[7:0] : 8'd0, mant[22:0]};
    end
  end

endmodule

### rtl/uq4_div.sv
// ----------------------------------------------------------------------------
// uq4_div
// Bit-serial mantissa divider that turns 16*d/range into a 4-bit code,
// honoring the round-to-nearest result of the float quotient.
// ----------------------------------------------------------------------------
module uq4_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] d_bits,
  input  logic [31:0] range_bits,
  output logic        done,
  output logic [3:0]  code
);
  import uq4_pkg::*;

  logic        run_r, done_r;
  logic [4:0]  cnt_r;
  logic [24:0] rem_r;
  logic [23:0] dvs_r;
  logic [29:0] q_r;
  logic [2:0]  rsh_r;
  logic [3:0]  code_r;

  logic signed [10:0] sh;
  logic        ge;
  logic [24:0] rem_sub;
  logic [30:0] q_new, u;
  logic [4:0]  ipart, k;

  always_comb begin
    sh      = 11'(d_bits[30:23]) + 11'sd4 - 11'(range_bits[30:23]);
    ge      = rem_r >= {1'b0, dvs_r};
    rem_sub = ge ? rem_r - {1'b0, dvs_r} : rem_r;
    q_new   = {q_r, ge};
    u       = q_new >> rsh_r;
    ipart   = u[30:26];
    k       = ipart + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r <= {1'b0, 1'b1, d_bits[22:0]};
        dvs_r <= {1'b1, range_bits[22:0]};
        q_r   <= '0;
        cnt_r <= 5'd31;
        rsh_r <= 3'(11'sd4 - sh);
        if (f_is_nan(d_bits) || d_bits[31] || f_is_nan(range_bits)) begin
          code_r <= '0;
          done_r <= 1'b1;
        end else if (d_bits[30:23] == 8'hFF) begin
          code_r <= (range_bits[30:23] == 8'hFF) ? 4'd0 : CODE_MAX;
          done_r <= 1'b1;
        end else if (d_bits[30:23] == 8'd0 || range_bits[30:23] == 8'hFF) begin
          code_r <= '0;
          done_r <= 1'b1;
        end else if (sh >= 11'sd5) begin
          code_r <= CODE_MAX;
          done_r <= 1'b1;
        end else if (sh <= -11'sd2) begin
          code_r <= '0;
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (run_r) begin
        q_r   <= q_new[29:0];
        rem_r <= {rem_sub[23:0], 1'b0};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
          if (ipart >= 5'd15) begin
            code_r <= CODE_MAX;
          end else if (u[25:0] >= up_thr(k)) begin
            code_r <= k[3:0];
          end else begin
            code_r <= ipart[3:0];
          end
        end
      end
    end
  end

  assign done = done_r;
  assign code = code_r;

endmodule

### rtl/uq4_chk.sv
// ----------------------------------------------------------------------------
// uq4_chk
// Port-level checks for the quantizer core, bound to the core module.
// ----------------------------------------------------------------------------
module uq4_chk #(
  parameter int BLOCK_ELEMENTS = 128
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input uq4_pkg::in_word_t  in_word,
  input logic               busy,
  input logic               out_valid,
  input uq4_pkg::out_word_t out_word
);
  import uq4_pkg::*;

  localparam int NUM_BYTES = (BLOCK_ELEMENTS + 1) / 2;

  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("word without block in flight");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last_byte |-> out_word.byte_index == 6'(NUM_BYTES - 1))
    else $error("last word at wrong index");

  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last_byte |-> busy) else $error("idle mid block");

  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_word.final_sample |=> busy)
    else $error("final value did not start block");

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back words");

endmodule

bind uniform_4bit_block_quantizer_core uq4_chk #(
  .BLOCK_ELEMENTS(BLOCK_ELEMENTS)
) u_uq4_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_word   (in_word),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);
